[rtl/akp_pkg.sv]
// Shared constants, codes and helpers for the analog keypad auto-repeat block.
package akp_pkg;

	// Key codes as reported on the result channel.
	localparam logic [2:0] KEY_NONE   = 3'd0;
	localparam logic [2:0] KEY_RIGHT  = 3'd1;
	localparam logic [2:0] KEY_UP     = 3'd2;
	localparam logic [2:0] KEY_DOWN   = 3'd3;
	localparam logic [2:0] KEY_LEFT   = 3'd4;
	localparam logic [2:0] KEY_SELECT = 3'd5;

	// Report modes.
	localparam logic [1:0] MODE_INSTANT  = 2'd0;
	localparam logic [1:0] MODE_PERIODIC = 2'd1;
	localparam logic [1:0] MODE_RELEASE  = 2'd2;
	localparam logic [1:0] MODE_FAST     = 2'd3;

	// Register indexes on the configuration port.
	localparam logic [2:0] REG_LEVELS     = 3'd0;
	localparam logic [2:0] REG_WINDOW     = 3'd1;
	localparam logic [2:0] REG_REFRESH    = 3'd2;
	localparam logic [2:0] REG_ACTIVATE   = 3'd3;
	localparam logic [2:0] REG_REPEAT     = 3'd4;
	localparam logic [2:0] REG_MIN_REPEAT = 3'd5;
	localparam logic [2:0] REG_MODE       = 3'd6;

	localparam int CFG_W = 50;

	// Reset values of the registers.
	localparam logic [49:0] LEVELS_RST     = {10'd741, 10'd503, 10'd142, 10'd326, 10'd0};
	localparam logic [9:0]  WINDOW_RST     = 10'd15;
	localparam logic [15:0] REFRESH_RST    = 16'd10;
	localparam logic [15:0] ACTIVATE_RST   = 16'd400;
	localparam logic [15:0] REPEAT_RST     = 16'd100;
	localparam logic [15:0] MIN_REPEAT_RST = 16'd20;
	localparam logic [1:0]  MODE_RST       = MODE_FAST;

	// True when the sample lies strictly inside (level - width, level + width).
	function automatic logic in_window(input logic [9:0] sample, input logic [9:0] level,
			input logic [9:0] width);
		logic signed [11:0] s;
		logic signed [11:0] lo;
		logic signed [11:0] hi;
		s  = $signed({2'b00, sample});
		lo = $signed({2'b00, level}) - $signed({2'b00, width});
		hi = $signed({2'b00, level}) + $signed({2'b00, width});
		return (s > lo) && (s < hi);
	endfunction

	// Priority decode: select, left, up, down, right.
	function automatic logic [2:0] decode_key(input logic [9:0] sample,
			input logic [49:0] levels, input logic [9:0] width);
		logic [2:0] k;
		k = KEY_NONE;
		if (in_window(sample, levels[49:40], width)) begin
			k = KEY_SELECT;
		end else if (in_window(sample, levels[39:30], width)) begin
			k = KEY_LEFT;
		end else if (in_window(sample, levels[29:20], width)) begin
			k = KEY_UP;
		end else if (in_window(sample, levels[19:10], width)) begin
			k = KEY_DOWN;
		end else if (in_window(sample, levels[9:0], width)) begin
			k = KEY_RIGHT;
		end
		return k;
	endfunction

endpackage

[rtl/analog_keypad_autorepeat.sv]
// Top level of the resistor-ladder keypad decoder with typematic repeat.
//
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------------------
//  poll in  | in_valid / in_stall    | now_ms[31:0], adc_sample[9:0]
//  key out  | out_valid / out_stall  | key_valid, key_code[2:0]
//  config   | cfg_wen                | cfg_index[2:0], cfg_wdata[49:0]
//
// A poll request goes from acceptance through S_EVAL and S_DONE to a filled output
// register when no repeat timing is needed. When a held key in fast-scroll mode
// must work out its repeat period, S_DIV1, S_DIV2 and S_CHECK lie in between; the
// bit-serial divider retires one quotient bit per cycle, first for the hold time
// divided by the activation time, then for the repeat time divided by that count.
// The block works on one request at a time; in_stall is high from acceptance until
// the result moves into the output register, which may still hold an earlier
// result that waits on out_stall. Reset is asynchronous and active low; it loads
// the register defaults and clears the history, with no clearing pass.
module analog_keypad_autorepeat
	import akp_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [31:0]         now_ms,
	input  logic [9:0]          adc_sample,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                key_valid,
	output logic [2:0]          key_code,
	input  logic                cfg_wen,
	input  logic [2:0]          cfg_index,
	input  logic [CFG_W-1:0]    cfg_wdata
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_EVAL  = 3'd1;
	localparam logic [2:0] S_DIV1  = 3'd2;
	localparam logic [2:0] S_DIV2  = 3'd3;
	localparam logic [2:0] S_CHECK = 3'd4;
	localparam logic [2:0] S_DONE  = 3'd5;

	// Configuration registers.
	logic [49:0] levels_q;
	logic [9:0]  window_q;
	logic [15:0] refresh_q;
	logic [15:0] activate_q;
	logic [15:0] repeat_q;
	logic [15:0] min_repeat_q;
	logic [1:0]  mode_q;

	// History kept from one poll to the next.
	logic [2:0]  prev_key_q;
	logic [31:0] last_sample_q;
	logic [31:0] change_time_q;
	logic [31:0] last_repeat_q;

	// Working registers of the current request.
	logic [2:0]  state_q;
	logic [31:0] now_q;
	logic [9:0]  adc_q;
	logic [2:0]  key_q;
	logic        res_valid_q;
	logic [2:0]  res_key_q;

	// Bit-serial divider: dividend shifts out of dq_q as quotient bits shift in.
	logic [31:0] dq_q;
	logic [15:0] rem_q;
	logic [31:0] div_q;
	logic [4:0]  cnt_q;

	// Output register.
	logic        out_valid_q;
	logic        key_valid_q;
	logic [2:0]  key_code_q;

	logic [2:0]  key_dec;
	logic [31:0] sample_due;
	logic        sample_ok;
	logic [15:0] act_eff;
	logic [31:0] held;
	logic        eval_hit;
	logic        eval_div;
	logic [16:0] trial;
	logic        trial_ge;
	logic [15:0] rem_next;
	logic [31:0] dq_next;
	logic [15:0] period;
	logic [31:0] repeat_due;
	logic        out_free;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign key_valid = key_valid_q;
	assign key_code  = key_code_q;
	assign out_free  = !out_valid_q || !out_stall;

	// Decode and periodic gate, evaluated once per request.
	assign key_dec    = decode_key(adc_q, levels_q, window_q);
	assign sample_due = last_sample_q + {16'd0, refresh_q};
	assign sample_ok  = now_q > sample_due;
	assign act_eff    = (activate_q == 16'd0) ? 16'd1 : activate_q;
	assign held       = now_q - change_time_q;

	// Instant mode always reports; periodic mode reports every fresh sample,
	// and the two history modes only a fresh sample with a changed key.
	assign eval_hit = (mode_q == MODE_INSTANT) ||
		(sample_ok && (mode_q == MODE_PERIODIC || key_dec != prev_key_q));
	// A key held past activation in fast scroll needs its repeat period worked out.
	assign eval_div = (mode_q == MODE_FAST) && sample_ok && (key_dec == prev_key_q) &&
		(key_dec != KEY_NONE) && (held > {16'd0, act_eff});

	// One restoring-division step per cycle.
	assign trial    = {rem_q, dq_q[31]};
	assign trial_ge = {15'd0, trial} >= div_q;
	assign rem_next = trial_ge ? 16'(trial - div_q[16:0]) : trial[15:0];
	assign dq_next  = {dq_q[30:0], trial_ge};

	// Repeat period from the second quotient, floored at the minimum.
	assign period     = (dq_q[15:0] < min_repeat_q) ? min_repeat_q : dq_q[15:0];
	assign repeat_due = last_repeat_q + {16'd0, period};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			levels_q      <= LEVELS_RST;
			window_q      <= WINDOW_RST;
			refresh_q     <= REFRESH_RST;
			activate_q    <= ACTIVATE_RST;
			repeat_q      <= REPEAT_RST;
			min_repeat_q  <= MIN_REPEAT_RST;
			mode_q        <= MODE_RST;
			prev_key_q    <= KEY_NONE;
			last_sample_q <= '0;
			change_time_q <= '0;
			last_repeat_q <= '0;
			state_q       <= S_IDLE;
			res_valid_q   <= 1'b0;
			res_key_q     <= KEY_NONE;
			out_valid_q   <= 1'b0;
			key_valid_q   <= 1'b0;
			key_code_q    <= KEY_NONE;
		end else begin
			if (cfg_wen) begin
				unique case (cfg_index)
					REG_LEVELS:     levels_q     <= cfg_wdata[49:0];
					REG_WINDOW:     window_q     <= cfg_wdata[9:0];
					REG_REFRESH:    refresh_q    <= cfg_wdata[15:0];
					REG_ACTIVATE:   activate_q   <= cfg_wdata[15:0];
					REG_REPEAT:     repeat_q     <= cfg_wdata[15:0];
					REG_MIN_REPEAT: min_repeat_q <= cfg_wdata[15:0];
					REG_MODE:       mode_q       <= cfg_wdata[1:0];
					default: ;
				endcase
			end

			// A finishing request refills the register in the same cycle.
			if (out_valid_q && !out_stall && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					key_q       <= key_dec;
					res_valid_q <= eval_hit;
					res_key_q   <= eval_hit ? key_dec : KEY_NONE;
					state_q     <= eval_div ? S_DIV1 : S_DONE;
					if (mode_q != MODE_INSTANT && sample_ok) begin
						last_sample_q <= now_q;
						if (mode_q != MODE_PERIODIC && key_dec != prev_key_q) begin
							prev_key_q <= key_dec;
							if (mode_q == MODE_FAST) begin
								// A key change, releases included, restarts the hold timer.
								last_repeat_q <= '0;
								change_time_q <= now_q;
							end
						end
					end
					if (eval_div) begin
						// Held past activation: count whole activation intervals.
						dq_q  <= held;
						div_q <= {16'd0, act_eff};
						rem_q <= '0;
						cnt_q <= 5'd31;
					end
				end
				S_DIV1: begin
					if (cnt_q == 5'd0) begin
						// The interval count becomes the divisor of the repeat time.
						div_q   <= dq_next;
						dq_q    <= {repeat_q, 16'd0};
						rem_q   <= '0;
						cnt_q   <= 5'd15;
						state_q <= S_DIV2;
					end else begin
						dq_q  <= dq_next;
						rem_q <= rem_next;
						cnt_q <= cnt_q - 5'd1;
					end
				end
				S_DIV2: begin
					dq_q  <= dq_next;
					rem_q <= rem_next;
					if (cnt_q == 5'd0) begin
						state_q <= S_CHECK;
					end else begin
						cnt_q <= cnt_q - 5'd1;
					end
				end
				S_CHECK: begin
					if (now_q > repeat_due) begin
						last_repeat_q <= now_q;
						res_valid_q   <= 1'b1;
						res_key_q     <= key_q;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						key_valid_q <= res_valid_q;
						key_code_q  <= res_key_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Input capture; payload registers need no reset.
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			now_q <= now_ms;
			adc_q <= adc_sample;
		end
	end

	// A new result appears only when a request has finished.
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == S_DONE))
		else $error("result appeared without a finished request");

	// A wait result always carries the no-key code.
	a_wait_is_none: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !key_valid) |-> (key_code == KEY_NONE))
		else $error("wait result carries a key code");

	// The repeat period quotient never exceeds the repeat time it came from.
	a_quotient_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHECK) |-> (dq_q[31:16] == 16'd0 && dq_q[15:0] <= repeat_q))
		else $error("repeat period quotient out of range");

	// The remembered key is always a real code.
	a_prev_key_code: assert property (@(posedge clk) disable iff (!arst_n)
		prev_key_q <= KEY_SELECT)
		else $error("remembered key holds an unused code");

endmodule

[verif/akp_report_checker.sv]
`timescale 1ns / 100ps
// Watches the poll and key channels, predicts every key report and compares it with the block's output.
module akp_report_checker
	import akp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_stall,
	input  logic [31:0]      now_ms,
	input  logic [9:0]       adc_sample,
	input  logic             out_valid,
	input  logic             out_stall,
	input  logic             key_valid,
	input  logic [2:0]       key_code,
	input  logic             cfg_wen,
	input  logic [2:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_wdata,
	output int               fail_count,
	output int               pending
);

	typedef struct packed {
		logic       hit;
		logic [2:0] code;
	} key_report_t;

	// Lowest priority first, so that a later match overrides an earlier one.
	localparam logic [2:0] KEY_ORDER [5] = '{KEY_RIGHT, KEY_DOWN, KEY_UP, KEY_LEFT, KEY_SELECT};

	key_report_t expected_reports[$];
	key_report_t head;

	logic [49:0] levels_r;
	logic [9:0]  width_r;
	logic [15:0] refresh_r;
	logic [15:0] activate_r;
	logic [15:0] repeat_r;
	logic [15:0] min_repeat_r;
	logic [1:0]  mode_r;

	logic [2:0]  prev_key;
	logic [31:0] sample_time;
	logic [31:0] change_time;
	logic [31:0] repeat_time;

	function automatic logic [2:0] match_key(input logic [9:0] sample);
		logic [2:0] k;
		int lev;
		int w;
		k = KEY_NONE;
		w = int'(width_r);
		for (int i = 0; i < 5; i++) begin
			lev = int'(levels_r[10*i +: 10]);
			if (int'(sample) > lev - w && int'(sample) < lev + w) begin
				k = KEY_ORDER[i];
			end
		end
		return k;
	endfunction

	// Works out the report for one accepted poll and advances the history.
	function automatic key_report_t predict_poll(input logic [31:0] t, input logic [9:0] sample);
		key_report_t r;
		logic        decoded;
		logic [2:0]  k;
		logic [31:0] due;
		logic [31:0] act;
		logic [31:0] held;
		logic [31:0] steps;
		logic [31:0] period;
		r = '0;
		k = KEY_NONE;
		decoded = 1'b0;
		due = sample_time + 32'(refresh_r);
		if (mode_r != MODE_INSTANT && t > due) begin
			decoded = 1'b1;
			sample_time = t;
			k = match_key(sample);
		end
		case (mode_r)
			MODE_INSTANT: begin
				r.hit = 1'b1;
				r.code = match_key(sample);
			end
			MODE_PERIODIC: begin
				if (decoded) begin
					r.hit = 1'b1;
					r.code = k;
				end
			end
			MODE_RELEASE: begin
				if (decoded && k != prev_key) begin
					prev_key = k;
					r.hit = 1'b1;
					r.code = k;
				end
			end
			default: begin
				if (decoded && k != prev_key) begin
					prev_key = k;
					repeat_time = '0;
					change_time = t;
					r.hit = 1'b1;
					r.code = k;
				end else if (decoded && k != KEY_NONE) begin
					act = (activate_r == 16'd0) ? 32'd1 : 32'(activate_r);
					held = t - change_time;
					if (held > act) begin
						steps = held / act;
						period = 32'(repeat_r) / steps;
						if (period < 32'(min_repeat_r)) begin
							period = 32'(min_repeat_r);
						end
						due = repeat_time + period;
						if (t > due) begin
							repeat_time = t;
							r.hit = 1'b1;
							r.code = k;
						end
					end
				end
			end
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			levels_r = LEVELS_RST;
			width_r = WINDOW_RST;
			refresh_r = REFRESH_RST;
			activate_r = ACTIVATE_RST;
			repeat_r = REPEAT_RST;
			min_repeat_r = MIN_REPEAT_RST;
			mode_r = MODE_RST;
			prev_key = KEY_NONE;
			sample_time = '0;
			change_time = '0;
			repeat_time = '0;
			expected_reports.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (cfg_wen) begin
				case (cfg_index)
					REG_LEVELS:     levels_r = cfg_wdata[49:0];
					REG_WINDOW:     width_r = cfg_wdata[9:0];
					REG_REFRESH:    refresh_r = cfg_wdata[15:0];
					REG_ACTIVATE:   activate_r = cfg_wdata[15:0];
					REG_REPEAT:     repeat_r = cfg_wdata[15:0];
					REG_MIN_REPEAT: min_repeat_r = cfg_wdata[15:0];
					REG_MODE:       mode_r = cfg_wdata[1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				expected_reports.push_back(predict_poll(now_ms, adc_sample));
			end
			if (out_valid && !out_stall) begin
				if (expected_reports.size() == 0) begin
					if (fail_count < 10) begin
						$display("%0t: key report with no poll waiting: valid=%0d key=%0d",
							$realtime, key_valid, key_code);
					end
					fail_count++;
				end else begin
					head = expected_reports.pop_front();
					if (key_valid !== head.hit || key_code !== head.code) begin
						if (fail_count < 10) begin
							$display("%0t: key report mismatch: expected valid=%0d key=%0d, got valid=%0d key=%0d",
								$realtime, head.hit, head.code, key_valid, key_code);
						end
						fail_count++;
					end
				end
			end
			pending = expected_reports.size();
		end
	end

endmodule

[verif/tb_analog_keypad_autorepeat.sv]
`timescale 1ns / 100ps
// Top of the keypad decoder testbench: clock, reset, poll and register stimulus, and the verdict.
module tb_analog_keypad_autorepeat;
	import akp_pkg::*;

	// Cycle limit of the whole run, set well above what the slowest correct run needs
	// with the sender gap, the divider and the receiver stall on every poll.
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int POLL_TARGET = 1200;
	localparam int WRAP_POLLS = 80;
	localparam int HOLD_OFF_CYCLES = 300;
	// Watch for stray reports after the last expected one has come.
	localparam int DRAIN_CYCLES = 60;

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_stall;
	logic [31:0]      now_ms;
	logic [9:0]       adc_sample;
	logic             out_valid;
	logic             out_stall;
	logic             key_valid;
	logic [2:0]       key_code;
	logic             cfg_wen;
	logic [2:0]       cfg_index;
	logic [CFG_W-1:0] cfg_wdata;

	int fail_count;
	int pending;
	int cycle_count = 0;
	int polls_sent = 0;

	// Local copies of the registers that shape the stimulus.
	logic [49:0] levels_cfg;
	logic [9:0]  width_cfg;
	logic [15:0] refresh_cfg;
	logic [15:0] activate_cfg;

	// Running millisecond clock of the keypad poller.
	logic [31:0] poll_time;

	// Quiet flags switch off the random gaps on one side; hold_req asks the
	// receiver for one long hold-off.
	bit quiet_sender = 1'b0;
	bit quiet_receiver = 1'b0;
	bit hold_req = 1'b0;

	analog_keypad_autorepeat uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.now_ms     (now_ms),
		.adc_sample (adc_sample),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.key_valid  (key_valid),
		.key_code   (key_code),
		.cfg_wen    (cfg_wen),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata)
	);

	akp_report_checker report_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.now_ms     (now_ms),
		.adc_sample (adc_sample),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.key_valid  (key_valid),
		.key_code   (key_code),
		.cfg_wen    (cfg_wen),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// A run that stops making progress ends here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Receiver: before each key report it waits a random number of cycles with
	// out_stall high, then takes the report as soon as it is offered. Once on
	// request it holds off for a long stretch so the block backs up onto its input.
	initial begin
		int wait_cycles;
		bit hold_taken;
		hold_taken = 1'b0;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req && !hold_taken) begin
				out_stall = 1'b1;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
				hold_taken = 1'b1;
			end
			wait_cycles = quiet_receiver ? 0 : $urandom_range(0, 17);
			if (wait_cycles > 0) begin
				out_stall = 1'b1;
				repeat (wait_cycles) @(negedge clk);
			end
			out_stall = 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	// Offers one poll request, after a random gap, and returns at the falling
	// edge after it was taken. With no gap, in_valid simply stays high.
	task automatic send_poll(input logic [31:0] t, input logic [9:0] sample);
		int gap;
		gap = quiet_sender ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		now_ms = t;
		adc_sample = sample;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		polls_sent++;
	endtask

	// Stops offering polls and waits until every expected key report has come.
	task automatic go_idle();
		in_valid = 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [CFG_W-1:0] value);
		cfg_wen = 1'b1;
		cfg_index = idx;
		cfg_wdata = value;
		@(negedge clk);
	endtask

	// Writes all seven registers back to back; only called while the block is idle.
	task automatic configure(input logic [49:0] lv, input logic [9:0] w, input logic [15:0] rf,
			input logic [15:0] ac, input logic [15:0] rp, input logic [15:0] mr,
			input logic [1:0] md);
		write_reg(REG_LEVELS, CFG_W'(lv));
		write_reg(REG_WINDOW, CFG_W'(w));
		write_reg(REG_REFRESH, CFG_W'(rf));
		write_reg(REG_ACTIVATE, CFG_W'(ac));
		write_reg(REG_REPEAT, CFG_W'(rp));
		write_reg(REG_MIN_REPEAT, CFG_W'(mr));
		write_reg(REG_MODE, CFG_W'(md));
		cfg_wen = 1'b0;
		levels_cfg = lv;
		width_cfg = w;
		refresh_cfg = rf;
		activate_cfg = ac;
	endtask

	// A sample that falls inside the window of the given key under the current
	// levels. Overlapping windows may still let a higher-priority key win, which
	// is fine. For "no key" any reading will do.
	function automatic logic [9:0] sample_for(input logic [2:0] k);
		int lev;
		int w;
		int off;
		int s;
		case (k)
			KEY_SELECT: lev = int'(levels_cfg[49:40]);
			KEY_LEFT:   lev = int'(levels_cfg[39:30]);
			KEY_UP:     lev = int'(levels_cfg[29:20]);
			KEY_DOWN:   lev = int'(levels_cfg[19:10]);
			KEY_RIGHT:  lev = int'(levels_cfg[9:0]);
			default:    return 10'($urandom);
		endcase
		w = int'(width_cfg);
		off = (w > 1) ? int'($urandom_range(0, 2 * w - 2)) - (w - 1) : 0;
		s = lev + off;
		if (s < 0) begin
			s = 0;
		end else if (s > 1023) begin
			s = 1023;
		end
		return 10'(s);
	endfunction

	// Random key presses: each key is held for a run of polls so that the
	// hold, repeat and acceleration paths are reached, with time steps sized
	// around the refresh interval and now and then a jump of up to just over
	// two activation intervals. One poll in eight is a stray reading.
	task automatic run_phase(input int n_polls);
		int left_polls;
		int run_len;
		int step_hi;
		int step;
		logic [2:0] k;
		left_polls = n_polls;
		step_hi = int'(refresh_cfg) + int'(refresh_cfg) / 2 + 4;
		while (left_polls > 0) begin
			k = 3'($urandom_range(KEY_NONE, KEY_SELECT));
			run_len = $urandom_range(1, 35);
			repeat (run_len) begin
				if ($urandom_range(0, 9) == 0) begin
					step = $urandom_range(0, 2 * int'(activate_cfg) + 2);
				end else begin
					step = $urandom_range(0, step_hi);
				end
				poll_time = poll_time + 32'(step);
				if ($urandom_range(0, 7) == 0) begin
					send_poll(poll_time, 10'($urandom));
				end else begin
					send_poll(poll_time, sample_for(k));
				end
				left_polls--;
			end
		end
	endtask

	// Picks a fresh register set. Every fifth phase puts all registers but the
	// mode at their lowest values and another every fifth at their highest.
	task automatic random_setup(input int phase);
		logic [49:0] lv;
		logic [9:0]  w;
		logic [15:0] rf;
		logic [15:0] ac;
		logic [15:0] rp;
		logic [15:0] mr;
		logic [1:0]  md;
		md = $urandom_range(0, 1) ? MODE_FAST : 2'($urandom_range(MODE_INSTANT, MODE_RELEASE));
		if (phase % 5 == 1) begin
			lv = '0;
			w = '0;
			rf = '0;
			ac = '0;
			rp = '0;
			mr = '0;
		end else if (phase % 5 == 3) begin
			lv = '1;
			w = '1;
			rf = '1;
			ac = '1;
			rp = '1;
			mr = '1;
		end else begin
			lv = ($urandom_range(0, 3) == 0) ? LEVELS_RST : 50'({$urandom, $urandom});
			w = 10'($urandom_range(1, 40));
			rf = 16'($urandom_range(0, 15));
			ac = 16'($urandom_range(5, 150));
			rp = 16'($urandom_range(0, 300));
			mr = 16'($urandom_range(0, 40));
		end
		configure(lv, w, rf, ac, rp, mr, md);
	endtask

	initial begin
		int phase;
		arst_n = 1'b0;
		in_valid = 1'b0;
		now_ms = '0;
		adc_sample = '0;
		cfg_wen = 1'b0;
		cfg_index = REG_LEVELS;
		cfg_wdata = '0;
		levels_cfg = LEVELS_RST;
		width_cfg = WINDOW_RST;
		refresh_cfg = REFRESH_RST;
		activate_cfg = ACTIVATE_RST;
		poll_time = '0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Fast scroll with the reset registers: a poll too early to be sampled,
		// a press, a release, then select held long enough to repeat, to speed
		// up, and to be held back by the shortened period.
		send_poll(32'd0, 10'd0);
		send_poll(32'd11, 10'd0);
		send_poll(32'd22, 10'd1023);
		send_poll(32'd33, 10'd741);
		send_poll(32'd600, 10'd741);
		send_poll(32'd1000, 10'd741);
		send_poll(32'd1021, 10'd741);
		send_poll(32'd1100, 10'd743);

		// Instant mode: the extreme timestamps and readings, and the edges of
		// the open select window, which must miss on the boundary itself.
		go_idle();
		configure(LEVELS_RST, WINDOW_RST, REFRESH_RST, ACTIVATE_RST, REPEAT_RST,
			MIN_REPEAT_RST, MODE_INSTANT);
		send_poll(32'hFFFF_FFFF, 10'h3FF);
		send_poll(32'd0, 10'd0);
		send_poll(32'd1200, 10'd726);
		send_poll(32'd1201, 10'd727);
		send_poll(32'd1202, 10'd755);
		send_poll(32'd1203, 10'd756);
		send_poll(32'd1204, 10'd326);
		send_poll(32'd1205, 10'd142);
		send_poll(32'd1206, 10'd503);

		// A zero activation time acts as one millisecond; with no refresh
		// spacing the repeat period collapses onto its floor.
		go_idle();
		configure(LEVELS_RST, WINDOW_RST, 16'd0, 16'd0, 16'd10, 16'd2, MODE_FAST);
		send_poll(32'd5000, 10'd326);
		send_poll(32'd5001, 10'd326);
		send_poll(32'd5003, 10'd326);
		send_poll(32'd5004, 10'd326);
		send_poll(32'd5006, 10'd142);

		// Wait-for-release reports a key once and stays quiet while it is held.
		go_idle();
		configure(LEVELS_RST, WINDOW_RST, REFRESH_RST, ACTIVATE_RST, REPEAT_RST,
			MIN_REPEAT_RST, MODE_RELEASE);
		send_poll(32'd6000, 10'd503);
		send_poll(32'd6020, 10'd503);
		poll_time = 32'd6100;

		// Back-pressure: the receiver holds off for a long stretch while the
		// sender keeps offering requests with no gaps, so the block fills and
		// stalls its input.
		go_idle();
		configure(LEVELS_RST, WINDOW_RST, REFRESH_RST, ACTIVATE_RST, REPEAT_RST,
			MIN_REPEAT_RST, MODE_FAST);
		quiet_sender = 1'b1;
		hold_req = 1'b1;
		repeat (15) begin
			poll_time = poll_time + 32'd7;
			send_poll(poll_time, sample_for(KEY_UP));
		end
		quiet_sender = 1'b0;

		// Random phases, each under its own register set and idling pattern.
		phase = 0;
		while (polls_sent < POLL_TARGET - WRAP_POLLS) begin
			go_idle();
			random_setup(phase);
			quiet_sender = ($urandom_range(0, 3) == 0);
			quiet_receiver = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 2) == 0) begin
				poll_time = poll_time + 32'($urandom_range(0, 1 << 24));
			end
			run_phase($urandom_range(40, 90));
			phase++;
		end

		// Last phase runs the millisecond clock through its wrap so the time
		// comparisons see wrapped sums.
		go_idle();
		quiet_sender = 1'b0;
		quiet_receiver = 1'b0;
		configure(LEVELS_RST, WINDOW_RST, REFRESH_RST, 16'd50, REPEAT_RST, 16'd5, MODE_FAST);
		poll_time = 32'hFFFF_FFFF - 32'($urandom_range(0, 600));
		run_phase(WRAP_POLLS);

		go_idle();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

[sim.f]
rtl/akp_pkg.sv
rtl/analog_keypad_autorepeat.sv
verif/akp_report_checker.sv
verif/tb_analog_keypad_autorepeat.sv
